// File: rtl/core/velocity_decimator_speed_macros.svh
// Assertion macros of the speed decimator, used by its sequencer vds_mag.
// Included by the files that check their own control logic.
`ifndef VELOCITY_DECIMATOR_SPEED_MACROS_SVH
`define VELOCITY_DECIMATOR_SPEED_MACROS_SVH

`ifndef SYNTHESIS
`define VDS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("velocity_decimator_speed: assertion failed");
`define VDS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("velocity_decimator_speed: assertion failed");
`define VDS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("velocity_decimator_speed: assertion failed");
`else
`define VDS_ASSERT(name, clk, rst_n, prop)
`define VDS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define VDS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/vds_pkg.sv
// Shared types, constants and helper functions of the speed decimator.
// No dependencies; used by every module of the block.
package vds_pkg;

  localparam int MagW   = 32;
  localparam int SqW    = 64;
  localparam int SumW   = 32;
  localparam int OutW   = 24;
  localparam int DivW   = 8;
  localparam int StepW  = 5;
  localparam int ModeW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [ModeW-1:0] ModeVert  = 2'd0;
  localparam logic [ModeW-1:0] ModeHoriz = 2'd1;
  localparam logic [ModeW-1:0] ModeFull  = 2'd2;
  localparam logic [ModeW-1:0] ModeBoth  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgBlockLength   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAverageEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSpeedMode     = 2'd2;

  localparam logic [DivW-1:0]  BlockLengthReset = 8'd5;
  localparam logic [OutW-1:0]  OutMax = 24'hFF_FFFF;

  typedef struct packed {
    logic             avg;
    logic [ModeW-1:0] mode;
    logic [DivW-1:0]  divisor;
    logic [MagW-1:0]  mag_x;
    logic [MagW-1:0]  mag_y;
    logic [MagW-1:0]  mag_z;
  } job_t;

  typedef struct packed {
    logic            has_vertical;
    logic [OutW-1:0] vertical_speed;
    logic [OutW-1:0] primary_speed;
  } res_t;

  function automatic logic [MagW-1:0] abs32(input logic [SumW-1:0] v);
    return v[SumW-1] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [OutW-1:0] sat24(input logic [SqW-1:0] v);
    return (v > SqW'(OutMax)) ? OutMax : v[OutW-1:0];
  endfunction

endpackage

// File: rtl/core/vds_csu.sv
// Shared compare-subtract unit: a >= b and a - b on 64-bit operands.
// Depends on vds_pkg for widths.
module vds_csu (
  input  logic [vds_pkg::SqW-1:0] a_i,
  input  logic [vds_pkg::SqW-1:0] b_i,
  output logic                    ge_o,
  output logic [vds_pkg::SqW-1:0] diff_o
);

  logic [vds_pkg::SqW:0] wide;

  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~wide[vds_pkg::SqW];
  assign diff_o = wide[vds_pkg::SqW-1:0];

endmodule

// File: rtl/core/vds_mag.sv
// Sequencer for averaging division, squaring and floor square root.
// Depends on vds_pkg, vds_csu and velocity_decimator_speed_macros.svh.
`include "velocity_decimator_speed_macros.svh"

module vds_mag (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vds_pkg::job_t job_i,
  output logic          idle_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output vds_pkg::res_t res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StSqr  = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam logic [vds_pkg::StepW-1:0] StepLast = vds_pkg::StepW'(vds_pkg::MagW - 1);
  localparam logic [vds_pkg::StepW-1:0] SqrLast  = vds_pkg::StepW'(3);
  localparam logic [1:0] AxisLast = 2'd2;

  logic [2:0] state_q, state_d;
  logic [vds_pkg::StepW-1:0] step_q, step_d;
  logic [1:0] axis_q, axis_d;
  logic [vds_pkg::ModeW-1:0] mode_q, mode_d;
  logic [vds_pkg::DivW-1:0] div_q, div_d;
  logic [vds_pkg::DivW-1:0] rem_q, rem_d;
  logic [vds_pkg::MagW-1:0] mx_q, mx_d, my_q, my_d, mz_q, mz_d;
  logic [vds_pkg::SqW-1:0] prod_q, prod_d;
  logic [vds_pkg::SqW-1:0] n_q, n_d;
  logic [vds_pkg::SqW-1:0] root_q, root_d;
  logic [vds_pkg::SqW-1:0] bit_q, bit_d;
  vds_pkg::res_t res_q, res_d;

  logic [vds_pkg::DivW:0] trial;
  logic [vds_pkg::MagW-1:0] shifted;
  logic [vds_pkg::SqW-1:0] csu_a, csu_b, csu_diff;
  logic csu_ge;

  vds_csu u_csu (
    .a_i    (csu_a),
    .b_i    (csu_b),
    .ge_o   (csu_ge),
    .diff_o (csu_diff)
  );

  assign trial   = {rem_q, mx_q[vds_pkg::MagW-1]};
  assign shifted = {mx_q[vds_pkg::MagW-2:0], csu_ge};

  always_comb begin
    csu_a = '0;
    csu_b = '0;
    unique case (state_q)
      StDiv: begin
        csu_a = vds_pkg::SqW'(trial);
        csu_b = vds_pkg::SqW'(div_q);
      end
      StRoot: begin
        csu_a = n_q;
        csu_b = root_q + bit_q;
      end
      default: begin
        csu_a = '0;
        csu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    mode_d  = mode_q;
    div_d   = div_q;
    rem_d   = rem_q;
    mx_d    = mx_q;
    my_d    = my_q;
    mz_d    = mz_q;
    prod_d  = prod_q;
    n_d     = n_q;
    root_d  = root_q;
    bit_d   = bit_q;
    res_d   = res_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          mode_d = job_i.mode;
          div_d  = job_i.divisor;
          mx_d   = job_i.mag_x;
          my_d   = job_i.mag_y;
          mz_d   = job_i.mag_z;
          step_d = '0;
          axis_d = '0;
          rem_d  = '0;
          n_d    = '0;
          state_d = job_i.avg ? StDiv : StSqr;
        end
      end
      StDiv: begin
        rem_d  = csu_ge ? csu_diff[vds_pkg::DivW-1:0] : trial[vds_pkg::DivW-1:0];
        mx_d   = shifted;
        step_d = step_q + 1'b1;
        if (step_q == StepLast) begin
          mx_d  = my_q;
          my_d  = mz_q;
          mz_d  = shifted;
          rem_d = '0;
          step_d = '0;
          if (axis_q == AxisLast) begin
            n_d = '0;
            state_d = StSqr;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      StSqr: begin
        if (step_q != SqrLast) begin
          prod_d = vds_pkg::SqW'(mx_q) * vds_pkg::SqW'(mx_q);
          mx_d = my_q;
          my_d = mz_q;
          mz_d = mx_q;
        end
        if ((step_q != '0) && ((step_q != SqrLast) || (mode_q == vds_pkg::ModeFull))) begin
          n_d = n_q + prod_q;
        end
        step_d = step_q + 1'b1;
        if (step_q == SqrLast) begin
          step_d = '0;
          root_d = '0;
          bit_d  = vds_pkg::SqW'(1) << (vds_pkg::SqW - 2);
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (csu_ge) begin
          n_d    = csu_diff;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 1'b1;
        if (step_q == StepLast) begin
          step_d = '0;
          res_d.primary_speed  = (mode_q == vds_pkg::ModeVert) ?
                                 vds_pkg::sat24(vds_pkg::SqW'(mz_q)) : vds_pkg::sat24(root_d);
          res_d.vertical_speed = (mode_q == vds_pkg::ModeBoth) ?
                                 vds_pkg::sat24(vds_pkg::SqW'(mz_q)) : '0;
          res_d.has_vertical   = (mode_q == vds_pkg::ModeBoth);
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    mz_q   <= mz_d;
    prod_q <= prod_d;
    n_q    <= n_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

  `VDS_ASSERT_IMP(a_start_idle, clk_i, rst_ni, start_i, state_q == StIdle)
  `VDS_ASSERT_NXT(a_done_hold, clk_i, rst_ni, (state_q == StDone) && !res_ready_i,
                  (state_q == StDone) && $stable(res_q))
  `VDS_ASSERT_IMP(a_root_bit, clk_i, rst_ni, state_q == StRoot, $onehot(bit_q))
  `VDS_ASSERT_IMP(a_sqr_step, clk_i, rst_ni, state_q == StSqr, step_q <= SqrLast)

endmodule

// File: rtl/core/velocity_decimator_speed.sv
// Speed decimator top level: configuration, block accumulation, output register.
// Depends on vds_pkg and vds_mag.
//
// Usage: velocity samples enter on the s_axis channel (x, y, z packed in tdata,
// x lowest). Samples gather into blocks of block_length; the last sample of a
// block launches one result, built from the block average or the last sample,
// which leaves on the m_axis channel (tdata: primary, vertical; tuser: flag).
// A sample that does not close a block is absorbed without stalling the input.
// In average mode the sequencer runs three 32-step divisions, then four squaring
// steps, then a 32-step root; in last-sample mode it skips the divisions. The
// divisions and the root share one compare-subtract unit.
// s_axis_tready_o stays low while that sequence runs and until its result is taken,
// so the block takes no new sample before the previous result has moved on.
// The config channel (cfg_index_i, cfg_data_i) is always ready; write it only
// while no result is pending.
// Reset clears the sums and the held count and loads block_length 5, average
// off and horizontal speed mode. A stalled receiver holds the output register;
// one further result waits in the sequencer, and then input stalls.
module velocity_decimator_speed #(
  parameter int COMPONENT_WIDTH = 24,
  parameter int MAX_BLOCK = 255,
  localparam int InDataW = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // vel_x, vel_y, vel_z from the lowest bit up, zero padded
  input  logic [InDataW-1:0]            s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // primary_speed, vertical_speed from the lowest bit up
  output logic [2*vds_pkg::OutW-1:0]    m_axis_tdata_o,
  // has_vertical
  output logic                          m_axis_tuser_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vds_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int LenCap = (MAX_BLOCK > 255) ? 255 : MAX_BLOCK;
  localparam int CntW   = (LenCap < 2) ? 1 : $clog2(LenCap + 1);
  localparam int CW     = COMPONENT_WIDTH;

  logic [vds_pkg::DivW-1:0]  block_length_q;
  logic                      average_enable_q;
  logic [vds_pkg::ModeW-1:0] speed_mode_q;
  logic [vds_pkg::SumW-1:0]  sum_x_q, sum_y_q, sum_z_q;
  logic [vds_pkg::SumW-1:0]  sum_x_n, sum_y_n, sum_z_n;
  logic [CntW-1:0]           held_q, count, len;
  logic                      out_valid_q;
  vds_pkg::res_t             out_q;

  logic signed [CW-1:0] xs, ys, zs;
  logic [vds_pkg::SumW-1:0] x32, y32, z32;
  logic in_accept, pass, close, start;
  logic mag_idle, res_valid, res_ready;
  vds_pkg::job_t job;
  vds_pkg::res_t res;

  assign xs = s_axis_tdata_i[CW-1:0];
  assign ys = s_axis_tdata_i[2*CW-1:CW];
  assign zs = s_axis_tdata_i[3*CW-1:2*CW];
  assign x32 = vds_pkg::SumW'(xs);
  assign y32 = vds_pkg::SumW'(ys);
  assign z32 = vds_pkg::SumW'(zs);

  assign sum_x_n = sum_x_q + x32;
  assign sum_y_n = sum_y_q + y32;
  assign sum_z_n = sum_z_q + z32;

  always_comb begin
    if (block_length_q == '0) begin
      len = CntW'(1);
    end else if (32'(block_length_q) > 32'(LenCap)) begin
      len = CntW'(LenCap);
    end else begin
      len = block_length_q[CntW-1:0];
    end
  end

  assign count     = held_q + 1'b1;
  assign pass      = (len == CntW'(1));
  assign close     = pass || (count >= len);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign start     = in_accept && close;
  assign s_axis_tready_o = mag_idle;

  always_comb begin
    job.mode    = speed_mode_q;
    job.avg     = average_enable_q && !pass;
    job.divisor = vds_pkg::DivW'(count);
    if (job.avg) begin
      job.mag_x = vds_pkg::abs32(sum_x_n);
      job.mag_y = vds_pkg::abs32(sum_y_n);
      job.mag_z = vds_pkg::abs32(sum_z_n);
    end else begin
      job.mag_x = vds_pkg::abs32(x32);
      job.mag_y = vds_pkg::abs32(y32);
      job.mag_z = vds_pkg::abs32(z32);
    end
  end

  vds_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .job_i       (job),
    .idle_o      (mag_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q   <= vds_pkg::BlockLengthReset;
      average_enable_q <= 1'b0;
      speed_mode_q     <= vds_pkg::ModeHoriz;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vds_pkg::CfgBlockLength:   block_length_q   <= cfg_data_i;
        vds_pkg::CfgAverageEnable: average_enable_q <= cfg_data_i[0];
        vds_pkg::CfgSpeedMode:     speed_mode_q     <= cfg_data_i[vds_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      held_q  <= '0;
    end else if (in_accept && !pass) begin
      if (close) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
        held_q  <= '0;
      end else begin
        sum_x_q <= sum_x_n;
        sum_y_q <= sum_y_n;
        sum_z_q <= sum_z_n;
        held_q  <= count;
      end
    end
  end

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.vertical_speed, out_q.primary_speed};
  assign m_axis_tuser_o  = out_q.has_vertical;

endmodule
